/* design/assert_macros.svh */
// Assertion macros shared by the slot table RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the property holds at every clock edge out of reset.
`define VPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Checks that the condition is never true at a clock edge out of reset.
`define VPS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* design/vps_pkg.sv */
// Shared types and constants of the payload slot table.
// No dependencies; used by the controller, the slot store and the top level.
`default_nettype none

package vps_pkg;

	localparam int SLOTS_DEF  = 64;
	localparam int ID_W       = 7;
	localparam int SLOT_W     = 6;
	localparam int OP_W       = 2;
	// Widest slot address for the supported table depths (up to 256).
	localparam int ADDR_MAX_W = 8;

	localparam logic [SLOT_W-1:0] CLEAR_ALL_COUNT = 6'h3f;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOCATE = 2'd0,
		OP_READ     = 2'd1,
		OP_ACK      = 2'd2
	} op_t;

	// Request from the controller to the slot store for one cycle.
	typedef struct packed {
		logic                  rd_en;
		logic [ADDR_MAX_W-1:0] rd_addr;
		logic                  wr_en;
		logic                  clr_one;
		logic                  clr_all;
		logic [ADDR_MAX_W-1:0] wr_addr;
		logic [ID_W-1:0]       wr_data;
	} mem_req_t;

endpackage

`default_nettype wire

/* design/vc_payload_slot_table.sv */
// Steps per beat: acknowledge, clear-all and unused beats go straight to the output register; a read
// waits for the registered RAM read; a fill writes the clamped run; a remove reads from start_slot to
// the end of the table, packs the kept slots down, then clears the freed slots, one RAM access a step.
// One beat is in flight at a time; a finished result waits in the output register while the
// next beat is taken. Reset is asynchronous and leaves every slot free through per-slot
// valid flags, so no clearing pass follows.
`default_nettype none

module vc_payload_slot_table #(
	parameter int SLOTS = vps_pkg::SLOTS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [vps_pkg::OP_W-1:0]   operation,
	input  wire logic [vps_pkg::ID_W-1:0]   payload_id,
	input  wire logic [vps_pkg::SLOT_W-1:0] start_slot,
	input  wire logic [vps_pkg::SLOT_W-1:0] slot_count,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [vps_pkg::ID_W-1:0]   slot_data,
	output logic                            table_updated
);

	import vps_pkg::*;

	mem_req_t        req;
	logic [ID_W-1:0] rd_data;

	vps_ctrl #(
		.SLOTS (SLOTS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.payload_id    (payload_id),
		.start_slot    (start_slot),
		.slot_count    (slot_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.slot_data     (slot_data),
		.table_updated (table_updated),
		.req           (req),
		.rd_data       (rd_data)
	);

	vps_slot_store #(
		.SLOTS (SLOTS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire

/* design/vps_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module vps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* design/vps_slot_store.sv */
// Slot store: the id RAM plus one valid flag per slot, so that reset and the
// clear-all command empty the table at once. Depends on vps_pkg and vps_ram.
`default_nettype none

module vps_slot_store #(
	parameter int SLOTS = vps_pkg::SLOTS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire vps_pkg::mem_req_t        req,
	output logic      [vps_pkg::ID_W-1:0] rd_data
);

	import vps_pkg::*;
	`include "assert_macros.svh"

	localparam int IDX_W = $clog2(SLOTS);

	logic [SLOTS-1:0] valid_q;
	logic             valid_s1;
	logic [ID_W-1:0]  ram_rdata;

	vps_ram #(
		.WIDTH (ID_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (req.wr_en),
		.wr_addr (req.wr_addr[IDX_W-1:0]),
		.wr_data (req.wr_data),
		.rd_en   (req.rd_en),
		.rd_addr (req.rd_addr[IDX_W-1:0]),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (req.clr_all) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr[IDX_W-1:0]] <= 1'b1;
			end else if (req.clr_one) begin
				valid_q[req.wr_addr[IDX_W-1:0]] <= 1'b0;
			end
			if (req.rd_en) begin
				valid_s1 <= valid_q[req.rd_addr[IDX_W-1:0]];
			end
		end
	end

	// A slot that was never written since the last clear reads as free.
	assign rd_data = valid_s1 ? ram_rdata : '0;

	`VPS_ASSERT_NEVER(a_one_write_kind, (req.clr_all && req.wr_en) ||
		(req.wr_en && req.clr_one), "Conflicting write requests to slot store")
	`VPS_ASSERT_NEVER(a_rd_addr_range, req.rd_en &&
		(int'(req.rd_addr) >= SLOTS), "Slot read beyond table depth")
	`VPS_ASSERT_NEVER(a_wr_addr_range, (req.wr_en || req.clr_one) &&
		(int'(req.wr_addr) >= SLOTS), "Slot write beyond table depth")

endmodule

`default_nettype wire

/* design/vps_ctrl.sv */
// Command sequencer: decodes each beat, walks the slot store for fill and
// remove, keeps the updated flag and the output register. Depends on vps_pkg.
`default_nettype none

module vps_ctrl #(
	parameter int SLOTS = vps_pkg::SLOTS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [vps_pkg::OP_W-1:0]   operation,
	input  wire logic [vps_pkg::ID_W-1:0]   payload_id,
	input  wire logic [vps_pkg::SLOT_W-1:0] start_slot,
	input  wire logic [vps_pkg::SLOT_W-1:0] slot_count,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [vps_pkg::ID_W-1:0]   slot_data,
	output logic                            table_updated,
	output vps_pkg::mem_req_t               req,
	input  wire logic [vps_pkg::ID_W-1:0]   rd_data
);

	import vps_pkg::*;
	`include "assert_macros.svh"

	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int EXT_W = (CNT_W > ID_W) ? CNT_W : ID_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_FILL,
		ST_REMOVE,
		ST_ZERO,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic            flag_q;
	logic [ID_W-1:0] res_q;
	logic [ID_W-1:0] id_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] end_q;
	logic [CNT_W-1:0] src_q;
	logic [CNT_W-1:0] dst_q;
	logic            src_busy_q;
	logic            rd_vld_s1;
	logic            out_valid_q;
	logic [ID_W-1:0] slot_data_q;
	logic            table_updated_q;

	op_t              op;
	logic             accept;
	logic             in_range;
	logic             clear_all;
	logic [EXT_W-1:0] start_ext;
	logic [EXT_W-1:0] sum_ext;
	logic [CNT_W-1:0] fill_end;
	logic             keep_slot;

	assign op        = op_t'(operation);
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign start_ext = EXT_W'(start_slot);
	assign sum_ext   = start_ext + EXT_W'(slot_count);
	assign in_range  = start_ext < EXT_W'(SLOTS);
	assign clear_all = (payload_id == '0) && (start_slot == '0) &&
		(slot_count == CLEAR_ALL_COUNT);
	// The fill run stops at the last slot of the table.
	assign fill_end  = (sum_ext > EXT_W'(SLOTS)) ? CNT_W'(SLOTS) : sum_ext[CNT_W-1:0];
	assign keep_slot = rd_vld_s1 && (rd_data != id_q);

	always_comb begin
		req = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_READ && in_range) begin
					req.rd_en   = 1'b1;
					req.rd_addr = ADDR_MAX_W'(start_slot);
				end
				if (accept && op == OP_ALLOCATE && clear_all) begin
					req.clr_all = 1'b1;
				end
			end
			ST_FILL: begin
				req.wr_en   = 1'b1;
				req.wr_addr = ADDR_MAX_W'(ptr_q);
				req.wr_data = id_q;
			end
			ST_REMOVE: begin
				// Reads run at least one slot ahead of the packed writes, and the write
				// pointer never passes the read pointer, so no forwarding is needed.
				req.rd_en   = src_busy_q;
				req.rd_addr = ADDR_MAX_W'(src_q);
				req.wr_en   = keep_slot;
				req.wr_addr = ADDR_MAX_W'(dst_q);
				req.wr_data = rd_data;
			end
			ST_ZERO: begin
				req.clr_one = 1'b1;
				req.wr_addr = ADDR_MAX_W'(dst_q);
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			flag_q          <= 1'b0;
			res_q           <= '0;
			id_q            <= '0;
			ptr_q           <= '0;
			end_q           <= '0;
			src_q           <= '0;
			dst_q           <= '0;
			src_busy_q      <= 1'b0;
			rd_vld_s1       <= 1'b0;
			out_valid_q     <= 1'b0;
			slot_data_q     <= '0;
			table_updated_q <= 1'b0;
		end else begin
			rd_vld_s1 <= req.rd_en;
			// A finished beat reloads the output register itself in ST_DONE.
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q <= '0;
						id_q  <= payload_id;
						case (op)
							OP_ALLOCATE: begin
								flag_q  <= 1'b1;
								state_q <= ST_DONE;
								if (!clear_all && in_range) begin
									if (slot_count == '0) begin
										src_q      <= CNT_W'(start_slot);
										dst_q      <= CNT_W'(start_slot);
										src_busy_q <= 1'b1;
										state_q    <= ST_REMOVE;
									end else begin
										ptr_q   <= CNT_W'(start_slot);
										end_q   <= fill_end;
										state_q <= ST_FILL;
									end
								end
							end
							OP_READ: begin
								state_q <= in_range ? ST_RD_WAIT : ST_DONE;
							end
							OP_ACK: begin
								flag_q  <= 1'b0;
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_RD_WAIT: begin
					res_q   <= rd_data;
					state_q <= ST_DONE;
				end
				ST_FILL: begin
					ptr_q <= ptr_q + CNT_W'(1);
					if (ptr_q + CNT_W'(1) == end_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_REMOVE: begin
					if (src_busy_q) begin
						src_q <= src_q + CNT_W'(1);
						if (src_q == CNT_W'(SLOTS - 1)) begin
							src_busy_q <= 1'b0;
						end
					end
					if (keep_slot) begin
						dst_q <= dst_q + CNT_W'(1);
					end
					if (!src_busy_q && !rd_vld_s1) begin
						state_q <= (dst_q == CNT_W'(SLOTS)) ? ST_DONE : ST_ZERO;
					end
				end
				ST_ZERO: begin
					dst_q <= dst_q + CNT_W'(1);
					if (dst_q == CNT_W'(SLOTS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q     <= 1'b1;
						slot_data_q     <= res_q;
						table_updated_q <= flag_q;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign slot_data     = slot_data_q;
	assign table_updated = table_updated_q;

	`VPS_ASSERT(a_fill_in_run, (state_q == ST_FILL) |-> (ptr_q < end_q),
		"Fill pointer ran past the end of its run")
	`VPS_ASSERT(a_pack_behind_read, (state_q == ST_REMOVE) |-> (dst_q <= src_q),
		"Packed write pointer overtook the read pointer")
	`VPS_ASSERT(a_done_delivers,
		(state_q == ST_DONE && (!out_valid_q || !out_stall)) |=>
		(out_valid_q && state_q == ST_IDLE),
		"Finished item was not moved to the output register")
	`VPS_ASSERT(a_ack_clears_flag,
		(accept && op == OP_ACK) |=> !flag_q,
		"Acknowledge left the updated flag set")

endmodule

`default_nettype wire
